@@ hdl/cpe_pkg.sv @@
// Shared types and constants for the column post encoder.
`timescale 1ns / 1ps

package cpe_pkg;

    localparam int TEXEL_W     = 8;
    localparam int WIDTH_W     = 11;
    localparam int HEIGHT_W    = 8;
    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 1;
    localparam int ROW_W       = 8;
    localparam int COL_W       = 11;
    localparam int OFS_W       = 22;
    localparam int SCOUNT_W    = 9;
    localparam int PACK_W      = 64;
    localparam int CNT_W       = 4;
    localparam int OUT_BYTES   = 8;
    localparam int TDATA_W     = 96;
    localparam int TUSER_W     = 2;
    localparam int HDR_BYTES   = 3;
    localparam int POST_EXTRA  = 4;
    localparam int OFS_BASE    = 8;
    localparam int MAX_COLUMNS = 1024;

    localparam logic [7:0] TERM_BYTE = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_EMPTY
    } state_t;

    typedef enum logic [2:0] {
        KIND_START,
        KIND_LEN,
        KIND_ZERO,
        KIND_MEM,
        KIND_TERM
    } byte_kind_t;

    typedef struct packed {
        logic accept;
        logic issue;
        logic load_empty;
    } cmd_t;

    typedef struct packed {
        logic any_bytes;
        logic col_start;
        logic issue_ready;
        logic more_bytes;
        logic final_sent;
        logic out_free;
    } status_t;

endpackage

@@ hdl/column_post_encoder_core.sv @@
// Column post encoder top level: controller plus datapath.
`timescale 1ns / 1ps
//
// Texels enter on the s_ channel, one column after another, top row first.
// Each result on the m_ channel carries up to eight bytes of post data,
// the byte count, and on the first result of a column the column offset.
// tlast marks the last result caused by one texel.
// The configuration port writes image_width (index 0) and image_height (index 1);
// the user must write them only while the block is idle, which is not enforced.
// A nonzero texel that neither starts nor ends a column gives no result.
// For a texel that emits bytes, the serializer moves one byte per cycle out
// of the single-port run buffer while the packer can take it, and the packer
// hands each full word to the output register.
// A texel that only starts a column gives one empty result.
// The next texel is accepted while the last result still waits in the output
// register. When the receiver stalls, the packer and serializer hold.
// Reset clears the column state, selects width 1 and height 1, and empties
// the output register; the run buffer needs no clearing.
//
module column_post_encoder_core #(
    parameter int MAX_ROWS = 254
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [cpe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cpe_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cpe_pkg::TEXEL_W-1:0]   s_tdata,   // [7:0] texel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cpe_pkg::TDATA_W-1:0]   m_tdata,   // [63:0] packed_bytes,
                                                     // [67:64] byte_count,
                                                     // [89:68] column_offset, rest zero
    output logic [cpe_pkg::TUSER_W-1:0]   m_tuser,   // [0] offset_valid, [1] column_end
    output logic                          m_tlast
);

    cpe_pkg::cmd_t    cmd;
    cpe_pkg::status_t st;

    cpe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    cpe_datapath #(
        .MAX_ROWS (MAX_ROWS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .st        (st),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

@@ hdl/cpe_ctrl.sv @@
// Controller state machine: request intake and result sequencing.
`timescale 1ns / 1ps

module cpe_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  cpe_pkg::status_t st,
    output cpe_pkg::cmd_t    cmd
);

    cpe_pkg::state_t state_reg;
    cpe_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cpe_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            cpe_pkg::ST_IDLE: begin
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    cmd.accept = 1'b1;
                    if (st.any_bytes) begin
                        state_next = cpe_pkg::ST_EMIT;
                    end else if (st.col_start) begin
                        state_next = cpe_pkg::ST_EMPTY;
                    end
                end
            end
            cpe_pkg::ST_EMIT: begin
                cmd.issue = st.issue_ready && st.more_bytes;
                if (st.final_sent) begin
                    state_next = cpe_pkg::ST_IDLE;
                end
            end
            cpe_pkg::ST_EMPTY: begin
                if (st.out_free) begin
                    cmd.load_empty = 1'b1;
                    state_next     = cpe_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cpe_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/cpe_datapath.sv @@
// Datapath: column state, run buffer, byte serializer, packer and output register.
`timescale 1ns / 1ps

module cpe_datapath #(
    parameter int MAX_ROWS = 254
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [cpe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cpe_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic [cpe_pkg::TEXEL_W-1:0]   s_tdata,
    input  cpe_pkg::cmd_t                 cmd,
    output cpe_pkg::status_t              st,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cpe_pkg::TDATA_W-1:0]   m_tdata,
    output logic [cpe_pkg::TUSER_W-1:0]   m_tuser,
    output logic                          m_tlast
);

    localparam int RUN_W = $clog2(MAX_ROWS + 1);
    localparam int AW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam logic [RUN_W-1:0]               RUN_MAX   = RUN_W'(MAX_ROWS);
    localparam logic [cpe_pkg::HEIGHT_W-1:0]   ROWS_MAX  = cpe_pkg::HEIGHT_W'(MAX_ROWS);
    localparam logic [cpe_pkg::WIDTH_W-1:0]    COLS_MAX  =
        cpe_pkg::WIDTH_W'(cpe_pkg::MAX_COLUMNS);
    localparam int PAD_W = cpe_pkg::TDATA_W - cpe_pkg::OFS_W - cpe_pkg::CNT_W
                           - cpe_pkg::PACK_W;

    logic [cpe_pkg::TEXEL_W-1:0] run_mem [MAX_ROWS];

    logic [cpe_pkg::WIDTH_W-1:0]  width_reg;
    logic [cpe_pkg::HEIGHT_W-1:0] height_reg;
    logic [RUN_W-1:0]             run_len_reg;
    logic [cpe_pkg::ROW_W-1:0]    run_start_reg;
    logic [cpe_pkg::ROW_W-1:0]    row_reg;
    logic [cpe_pkg::COL_W-1:0]    col_reg;
    logic [cpe_pkg::OFS_W-1:0]    bytes_reg;

    logic [RUN_W-1:0]             post_len_reg;
    logic [cpe_pkg::ROW_W-1:0]    post_start_reg;
    logic                         col_end_reg;
    logic                         first_reg;
    logic [cpe_pkg::SCOUNT_W-1:0] scount_reg;
    logic [cpe_pkg::OFS_W-1:0]    offset_reg;
    logic [cpe_pkg::SCOUNT_W-1:0] idx_reg;

    logic                         b_vld_reg;
    logic                         b_mem_reg;
    logic                         b_last_reg;
    logic [7:0]                   b_byte_reg;
    logic [7:0]                   rd_reg;

    logic [cpe_pkg::PACK_W-1:0]   pk_word_reg;
    logic [cpe_pkg::PACK_W-1:0]   pk_word_next;
    logic [cpe_pkg::CNT_W-1:0]    pk_cnt_reg;
    logic                         pk_final_reg;

    logic                         m_tvalid_reg;
    logic [cpe_pkg::TDATA_W-1:0]  m_tdata_reg;
    logic [cpe_pkg::TUSER_W-1:0]  m_tuser_reg;
    logic                         m_tlast_reg;

    logic [cpe_pkg::HEIGHT_W-1:0] eh;
    logic [cpe_pkg::WIDTH_W-1:0]  ew;
    logic                         texel_zero;
    logic [cpe_pkg::ROW_W:0]      row_inc;
    logic                         col_end_now;
    logic [RUN_W-1:0]             run_app;
    logic [RUN_W-1:0]             post_len_now;
    logic                         has_post_now;
    logic [cpe_pkg::SCOUNT_W-1:0] scount_now;
    logic [cpe_pkg::OFS_W-1:0]    offset_now;
    logic [cpe_pkg::COL_W:0]      col_inc;
    logic                         img_end;

    logic                         has_post;
    logic [cpe_pkg::SCOUNT_W-1:0] post_len_ext;
    cpe_pkg::byte_kind_t          kind;
    logic [7:0]                   fixed_byte;
    logic [cpe_pkg::SCOUNT_W-1:0] mem_idx;
    logic [AW-1:0]                mem_addr;
    logic [7:0]                   b_val;
    logic                         pk_done;
    logic                         pk_take;
    logic                         out_free;
    logic                         xfer;

    // column state arithmetic for the incoming request
    always_comb begin
        if (height_reg == '0) begin
            eh = cpe_pkg::HEIGHT_W'(1);
        end else if (height_reg > ROWS_MAX) begin
            eh = ROWS_MAX;
        end else begin
            eh = height_reg;
        end
        if (width_reg == '0) begin
            ew = cpe_pkg::WIDTH_W'(1);
        end else if (width_reg > COLS_MAX) begin
            ew = COLS_MAX;
        end else begin
            ew = width_reg;
        end
        texel_zero   = (s_tdata == '0);
        row_inc      = {1'b0, row_reg} + (cpe_pkg::ROW_W + 1)'(1);
        col_end_now  = (row_inc >= {1'b0, eh});
        run_app      = (run_len_reg < RUN_MAX) ? run_len_reg + RUN_W'(1) : run_len_reg;
        if (texel_zero) begin
            post_len_now = run_len_reg;
        end else if (col_end_now) begin
            post_len_now = run_app;
        end else begin
            post_len_now = '0;
        end
        has_post_now = (post_len_now != '0);
        scount_now   = (has_post_now ? cpe_pkg::SCOUNT_W'(post_len_now)
                                       + cpe_pkg::SCOUNT_W'(cpe_pkg::POST_EXTRA) : '0)
                       + cpe_pkg::SCOUNT_W'(col_end_now);
        offset_now   = cpe_pkg::OFS_W'({ew, 2'b00}) + cpe_pkg::OFS_W'(cpe_pkg::OFS_BASE)
                       + bytes_reg;
        col_inc      = {1'b0, col_reg} + (cpe_pkg::COL_W + 1)'(1);
        img_end      = (col_inc >= (cpe_pkg::COL_W + 1)'(ew));
    end

    // byte selection for the serializer
    always_comb begin
        has_post     = (post_len_reg != '0);
        post_len_ext = cpe_pkg::SCOUNT_W'(post_len_reg);
        if (!has_post) begin
            kind = cpe_pkg::KIND_TERM;
        end else if (idx_reg == cpe_pkg::SCOUNT_W'(0)) begin
            kind = cpe_pkg::KIND_START;
        end else if (idx_reg == cpe_pkg::SCOUNT_W'(1)) begin
            kind = cpe_pkg::KIND_LEN;
        end else if (idx_reg == cpe_pkg::SCOUNT_W'(2)) begin
            kind = cpe_pkg::KIND_ZERO;
        end else if (idx_reg < post_len_ext + cpe_pkg::SCOUNT_W'(cpe_pkg::HDR_BYTES)) begin
            kind = cpe_pkg::KIND_MEM;
        end else if (idx_reg == post_len_ext + cpe_pkg::SCOUNT_W'(cpe_pkg::HDR_BYTES)) begin
            kind = cpe_pkg::KIND_ZERO;
        end else begin
            kind = cpe_pkg::KIND_TERM;
        end
        case (kind)
            cpe_pkg::KIND_START: fixed_byte = post_start_reg;
            cpe_pkg::KIND_LEN:   fixed_byte = 8'(post_len_reg);
            cpe_pkg::KIND_TERM:  fixed_byte = cpe_pkg::TERM_BYTE;
            default:             fixed_byte = 8'h00;
        endcase
        mem_idx  = idx_reg - cpe_pkg::SCOUNT_W'(cpe_pkg::HDR_BYTES);
        mem_addr = mem_idx[AW-1:0];
    end

    // packer and handshake status
    always_comb begin
        b_val    = b_mem_reg ? rd_reg : b_byte_reg;
        pk_done  = (pk_cnt_reg == cpe_pkg::CNT_W'(cpe_pkg::OUT_BYTES)) || pk_final_reg;
        pk_take  = b_vld_reg && !pk_done;
        out_free = !m_tvalid_reg || m_tready;
        xfer     = pk_done && out_free;
        pk_word_next = pk_word_reg;
        for (int l = 0; l < cpe_pkg::OUT_BYTES; l++) begin
            if (pk_cnt_reg == cpe_pkg::CNT_W'(l)) begin
                pk_word_next[8*l +: 8] = b_val;
            end
        end
        st.any_bytes   = has_post_now || col_end_now;
        st.col_start   = (row_reg == '0);
        st.issue_ready = !b_vld_reg || pk_take;
        st.more_bytes  = (idx_reg < scount_reg);
        st.final_sent  = xfer && pk_final_reg;
        st.out_free    = out_free;
    end

    // run buffer: write on append, registered read on issue
    always_ff @(posedge aclk) begin
        if (cmd.accept && !texel_zero && (run_len_reg < RUN_MAX)) begin
            run_mem[run_len_reg[AW-1:0]] <= s_tdata;
        end
        if (cmd.issue && (kind == cpe_pkg::KIND_MEM)) begin
            rd_reg <= run_mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= cpe_pkg::WIDTH_W'(1);
            height_reg    <= cpe_pkg::HEIGHT_W'(1);
            run_len_reg   <= '0;
            run_start_reg <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            bytes_reg     <= '0;
            post_len_reg  <= '0;
            col_end_reg   <= 1'b0;
            first_reg     <= 1'b0;
            scount_reg    <= '0;
            idx_reg       <= '0;
            b_vld_reg     <= 1'b0;
            pk_word_reg   <= '0;
            pk_cnt_reg    <= '0;
            pk_final_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    cpe_pkg::REG_WIDTH:  width_reg  <= cfg_wdata;
                    cpe_pkg::REG_HEIGHT: height_reg <= cfg_wdata[cpe_pkg::HEIGHT_W-1:0];
                    default: ;
                endcase
            end

            if (cmd.accept) begin
                post_len_reg   <= post_len_now;
                post_start_reg <= run_start_reg;
                col_end_reg    <= col_end_now;
                first_reg      <= (row_reg == '0);
                scount_reg     <= scount_now;
                offset_reg     <= offset_now;
                idx_reg        <= '0;
                if (col_end_now) begin
                    run_len_reg   <= '0;
                    run_start_reg <= '0;
                    row_reg       <= '0;
                    if (img_end) begin
                        col_reg   <= '0;
                        bytes_reg <= '0;
                    end else begin
                        col_reg   <= col_inc[cpe_pkg::COL_W-1:0];
                        bytes_reg <= bytes_reg + cpe_pkg::OFS_W'(scount_now);
                    end
                end else begin
                    row_reg   <= row_inc[cpe_pkg::ROW_W-1:0];
                    bytes_reg <= bytes_reg + cpe_pkg::OFS_W'(scount_now);
                    if (texel_zero) begin
                        run_len_reg   <= '0;
                        run_start_reg <= row_inc[cpe_pkg::ROW_W-1:0];
                    end else begin
                        run_len_reg <= run_app;
                    end
                end
            end

            if (cmd.issue) begin
                b_vld_reg  <= 1'b1;
                b_mem_reg  <= (kind == cpe_pkg::KIND_MEM);
                b_byte_reg <= fixed_byte;
                b_last_reg <= (idx_reg + cpe_pkg::SCOUNT_W'(1) == scount_reg);
                idx_reg    <= idx_reg + cpe_pkg::SCOUNT_W'(1);
            end else if (pk_take) begin
                b_vld_reg <= 1'b0;
            end

            if (xfer) begin
                pk_word_reg  <= '0;
                pk_cnt_reg   <= '0;
                pk_final_reg <= 1'b0;
            end else if (pk_take) begin
                pk_word_reg  <= pk_word_next;
                pk_cnt_reg   <= pk_cnt_reg + cpe_pkg::CNT_W'(1);
                pk_final_reg <= b_last_reg;
            end

            if (cmd.load_empty || xfer) begin
                first_reg    <= 1'b0;
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {{PAD_W{1'b0}},
                                 first_reg ? offset_reg : cpe_pkg::OFS_W'(0),
                                 cmd.load_empty ? cpe_pkg::CNT_W'(0) : pk_cnt_reg,
                                 cmd.load_empty ? cpe_pkg::PACK_W'(0) : pk_word_reg};
                m_tuser_reg  <= {col_end_reg && (cmd.load_empty || pk_final_reg), first_reg};
                m_tlast_reg  <= cmd.load_empty || pk_final_reg;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

@@ hdl/cpe_checker.sv @@
// Port checker for the column post encoder and its bind.
`timescale 1ns / 1ps

module cpe_port_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [cpe_pkg::TDATA_W-1:0] m_tdata,
    input logic [cpe_pkg::TUSER_W-1:0] m_tuser,
    input logic                        m_tlast
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    a_full_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[67:64] == 4'd8)
        else $error("non-final result not full");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[67:64] <= 4'd8)
        else $error("byte count out of range");

    a_term_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast && m_tdata[67:64] != 4'd0)
        else $error("column end not on last result");

    a_offset_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[89:68] == 22'd0)
        else $error("offset present without offset_valid");

endmodule

bind column_post_encoder_core cpe_port_checker u_cpe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

@@ dv/cpe_checker.sv @@
// Checker for the column post encoder: predicts result words and compares them.
`timescale 1ns / 1ps

module cpe_checker #(
    parameter int MAX_ROWS = 254
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [cpe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cpe_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [cpe_pkg::TEXEL_W-1:0]   s_tdata,   // [7:0] texel
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [cpe_pkg::TDATA_W-1:0]   m_tdata,   // [63:0] packed_bytes,
                                                     // [67:64] byte_count,
                                                     // [89:68] column_offset
    input  logic [cpe_pkg::TUSER_W-1:0]   m_tuser,   // [0] offset_valid, [1] column_end
    input  logic                          m_tlast,
    output int unsigned                   fail_count,
    output int unsigned                   pending
);

    typedef struct packed {
        logic [cpe_pkg::PACK_W-1:0] packed_bytes;
        logic [cpe_pkg::CNT_W-1:0]  byte_count;
        logic [cpe_pkg::OFS_W-1:0]  column_offset;
        logic                       offset_valid;
        logic                       column_end;
        logic                       last;
    } post_word_t;

    logic [cpe_pkg::TEXEL_W-1:0]  run_texels [0:MAX_ROWS-1];
    logic [cpe_pkg::ROW_W-1:0]    run_len;
    logic [cpe_pkg::ROW_W-1:0]    run_start;
    logic [cpe_pkg::ROW_W-1:0]    row_cnt;
    logic [cpe_pkg::COL_W-1:0]    col_cnt;
    logic [cpe_pkg::OFS_W-1:0]    bytes_out;
    logic [cpe_pkg::WIDTH_W-1:0]  cfg_width;
    logic [cpe_pkg::HEIGHT_W-1:0] cfg_height;

    logic [7:0]  texel_bytes [$];
    post_word_t  post_words_due [$];
    int unsigned errors = 0;

    task automatic append_post();
        if (run_len != 0) begin
            texel_bytes.push_back(run_start);
            texel_bytes.push_back(run_len);
            texel_bytes.push_back(8'h00);
            for (int i = 0; i < run_len; i++)
                texel_bytes.push_back(run_texels[i]);
            texel_bytes.push_back(8'h00);
        end
    endtask

    task automatic encode_texel(input logic [cpe_pkg::TEXEL_W-1:0] texel);
        int eff_h;
        int eff_w;
        int nres;
        int idx;
        logic [cpe_pkg::OFS_W-1:0] col_ofs;
        logic col_start;
        logic col_done;
        post_word_t w;

        eff_h = (cfg_height == 0) ? 1 : (cfg_height > MAX_ROWS) ? MAX_ROWS : cfg_height;
        eff_w = (cfg_width == 0) ? 1 :
                (cfg_width > cpe_pkg::MAX_COLUMNS) ? cpe_pkg::MAX_COLUMNS : cfg_width;
        col_ofs = cpe_pkg::OFS_W'(4 * eff_w + cpe_pkg::OFS_BASE + bytes_out);
        col_start = (row_cnt == 0);
        col_done = 1'b0;
        texel_bytes.delete();

        if (texel == 0) begin
            append_post();
            run_len = '0;
            run_start = row_cnt + 8'd1;
        end else if (run_len < MAX_ROWS) begin
            run_texels[run_len] = texel;
            run_len = run_len + 8'd1;
        end

        if (row_cnt + 1 >= eff_h) begin
            append_post();
            texel_bytes.push_back(cpe_pkg::TERM_BYTE);
            col_done = 1'b1;
            row_cnt = '0;
            run_len = '0;
            run_start = '0;
        end else begin
            row_cnt = row_cnt + 8'd1;
        end

        bytes_out = cpe_pkg::OFS_W'(bytes_out + texel_bytes.size());

        if (col_done) begin
            col_cnt = col_cnt + 11'd1;
            if (col_cnt >= eff_w) begin
                col_cnt = '0;
                bytes_out = '0;
            end
        end

        nres = (texel_bytes.size() + 7) / 8;
        if (nres == 0 && col_start)
            nres = 1;

        for (int k = 0; k < nres; k++) begin
            w = '0;
            for (int j = 0; j < cpe_pkg::OUT_BYTES; j++) begin
                idx = k * cpe_pkg::OUT_BYTES + j;
                if (idx < texel_bytes.size()) begin
                    w.packed_bytes[8*j +: 8] = texel_bytes[idx];
                    w.byte_count = w.byte_count + 4'd1;
                end
            end
            if (k == 0 && col_start) begin
                w.column_offset = col_ofs;
                w.offset_valid = 1'b1;
            end
            w.last = (k + 1 == nres);
            w.column_end = col_done && w.last;
            post_words_due.push_back(w);
        end
    endtask

    task automatic check_word();
        post_word_t want;

        if (post_words_due.size() == 0) begin
            $error("result with none expected: tdata %h tuser %b tlast %b",
                   m_tdata, m_tuser, m_tlast);
            errors++;
        end else begin
            want = post_words_due.pop_front();
            if (m_tdata[63:0] !== want.packed_bytes) begin
                $error("packed_bytes: expected %h, got %h", want.packed_bytes, m_tdata[63:0]);
                errors++;
            end
            if (m_tdata[67:64] !== want.byte_count) begin
                $error("byte_count: expected %0d, got %0d", want.byte_count, m_tdata[67:64]);
                errors++;
            end
            if (m_tdata[89:68] !== want.column_offset) begin
                $error("column_offset: expected %0d, got %0d",
                       want.column_offset, m_tdata[89:68]);
                errors++;
            end
            if (m_tuser[0] !== want.offset_valid) begin
                $error("offset_valid: expected %b, got %b", want.offset_valid, m_tuser[0]);
                errors++;
            end
            if (m_tuser[1] !== want.column_end) begin
                $error("column_end: expected %b, got %b", want.column_end, m_tuser[1]);
                errors++;
            end
            if (m_tlast !== want.last) begin
                $error("last: expected %b, got %b", want.last, m_tlast);
                errors++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            run_len = '0;
            run_start = '0;
            row_cnt = '0;
            col_cnt = '0;
            bytes_out = '0;
            cfg_width = cpe_pkg::WIDTH_W'(1);
            cfg_height = cpe_pkg::HEIGHT_W'(1);
            post_words_due.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == cpe_pkg::REG_WIDTH)
                    cfg_width = cfg_wdata[cpe_pkg::WIDTH_W-1:0];
                else if (cfg_index == cpe_pkg::REG_HEIGHT)
                    cfg_height = cfg_wdata[cpe_pkg::HEIGHT_W-1:0];
            end
            if (m_tvalid && m_tready)
                check_word();
            if (s_tvalid && s_tready)
                encode_texel(s_tdata);
        end
        pending <= post_words_due.size();
        fail_count <= errors;
    end

endmodule

@@ dv/tb_top.sv @@
// Testbench top for the column post encoder: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_ROWS    = 254;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 8;

    logic                          aclk;
    logic                          aresetn   = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [cpe_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [cpe_pkg::CFG_W-1:0]     cfg_wdata = '0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [cpe_pkg::TEXEL_W-1:0]   s_tdata   = '0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [cpe_pkg::TDATA_W-1:0]   m_tdata;   // [63:0] packed_bytes, [67:64] byte_count,
                                              // [89:68] column_offset
    logic [cpe_pkg::TUSER_W-1:0]   m_tuser;   // [0] offset_valid, [1] column_end
    logic                          m_tlast;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned cycle_count = 0;
    int unsigned ready_cycle = 0;
    int          ready_mode  = 0;
    int          burst_left  = 0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    column_post_encoder_core #(
        .MAX_ROWS(MAX_ROWS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    cpe_checker #(
        .MAX_ROWS(MAX_ROWS)
    ) i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // receiver: switch between four stall patterns, chosen at random
    always @(posedge aclk) begin
        ready_cycle++;
        if (ready_cycle % 50 == 0)
            ready_mode = $urandom_range(0, 3);
        case (ready_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (ready_cycle % 4 == 0);
            default: m_tready <= ($urandom_range(0, 99) < 85);
        endcase
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** column_post_encoder_core: FAILED **");
            $finish;
        end
    end

    task automatic send_texel(input logic [cpe_pkg::TEXEL_W-1:0] texel);
        int gap;

        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= texel;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
    endtask

    // hold until every expected word is out, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [cpe_pkg::CFG_IDX_W-1:0] index, input int value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= cpe_pkg::CFG_W'(value);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        logic [7:0] single_cols [5]  = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd127};
        logic [7:0] short_cols  [20] = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                                         8'd7, 8'd8, 8'd9, 8'd10, 8'd11,
                                         8'd0, 8'd5, 8'd0, 8'd6, 8'd6,
                                         8'd1, 8'd0, 8'd0, 8'd2, 8'd0};
        int phase_w     [5] = '{5, 0, 2, 1024, 2047};
        int phase_h     [5] = '{7, 0, 16, 3, 100};
        int phase_cols  [5] = '{3, 8, 2, 6, 1};
        bit phase_dense [5] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1};
        int zero_pcts   [6] = '{0, 10, 30, 50, 90, 100};
        int rows;
        int zero_pct;
        bit noise;
        logic [7:0] texel;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // one-row columns at reset defaults
        foreach (single_cols[i])
            send_texel(single_cols[i]);

        // empty column, full run, split runs, run closed by column end
        drain();
        write_reg(cpe_pkg::REG_WIDTH, 3);
        write_reg(cpe_pkg::REG_HEIGHT, 5);
        foreach (short_cols[i])
            send_texel(short_cols[i]);

        // out-of-range settings, then lower the height mid-column
        drain();
        write_reg(cpe_pkg::REG_WIDTH, 0);
        write_reg(cpe_pkg::REG_HEIGHT, 255);
        send_texel(8'd9);
        send_texel(8'd9);
        send_texel(8'd0);
        drain();
        write_reg(cpe_pkg::REG_HEIGHT, 2);
        send_texel(8'd4);

        foreach (phase_w[p]) begin
            drain();
            write_reg(cpe_pkg::REG_WIDTH, phase_w[p]);
            write_reg(cpe_pkg::REG_HEIGHT, phase_h[p]);
            rows = (phase_h[p] == 0) ? 1 : (phase_h[p] > MAX_ROWS) ? MAX_ROWS : phase_h[p];
            for (int c = 0; c < phase_cols[p]; c++) begin
                zero_pct = phase_dense[p] ? 0 : zero_pcts[$urandom_range(0, 5)];
                noise = !phase_dense[p] && ($urandom_range(0, 7) == 0);
                for (int r = 0; r < rows; r++) begin
                    if (noise)
                        texel = 8'($urandom_range(0, 255));
                    else if ($urandom_range(0, 99) < zero_pct)
                        texel = 8'd0;
                    else
                        texel = 8'($urandom_range(1, 255));
                    send_texel(texel);
                end
            end
        end

        drain();
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("** column_post_encoder_core: PASSED **");
        end else begin
            $display("** column_post_encoder_core: FAILED **");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/cpe_pkg.sv
hdl/cpe_ctrl.sv
hdl/cpe_datapath.sv
hdl/column_post_encoder_core.sv
hdl/cpe_checker.sv
dv/cpe_checker.sv
dv/tb_top.sv
